// ===== hdl/pcps_pkg.sv =====
// shared types, constants and helpers for the pll clock plan solver
package pcps_pkg;

    localparam int SRC_W       = 26;
    localparam int HCLK_W      = 28;
    localparam int VCO_W       = 35;
    localparam int ACC_W       = 29;
    localparam int DIV_STEPS   = 26;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int REQ_W       = 127;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_W       = 26;

    localparam logic [31:0]       SYS_MAX_HZ    = 32'd216000000;
    localparam logic [VCO_W-1:0]  VCO_MIN_HZ    = 35'd100000000;
    localparam logic [VCO_W-1:0]  VCO_MAX_HZ    = 35'd432000000;
    localparam logic [HCLK_W-1:0] APB1_STEP0_HZ = 28'd54000000;
    localparam logic [HCLK_W-1:0] APB_STEP1_HZ  = 28'd108000000;
    localparam logic [SRC_W-1:0]  INT_OSC_RST   = 26'd16000000;

    localparam logic [5:0] M_FIRST      = 6'd2;
    localparam logic [5:0] M_LAST       = 6'd63;
    localparam logic [8:0] N_FIRST      = 9'd50;
    localparam logic [8:0] N_LAST       = 9'd432;
    localparam logic [3:0] WS_MAX       = 4'd9;
    localparam logic [2:0] APB_CODE_MAX = 3'd4;
    localparam logic [3:0] POST_LAST    = 4'd9;

    // source mode codes
    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_EXT  = 2'd1;
    localparam logic [1:0] MODE_INT  = 2'd2;
    localparam logic [1:0] MODE_BAD  = 2'd3;

    // configuration register indexes
    localparam logic CFG_INT_OSC = 1'b0;
    localparam logic CFG_SUPPLY  = 1'b1;

    typedef struct packed {
        logic [31:0]      apb2_target_hz;
        logic             apb2_manual;
        logic [31:0]      apb1_target_hz;
        logic             apb1_manual;
        logic [31:0]      target_freq_hz;
        logic             hse_ready;
        logic [SRC_W-1:0] ext_freq_hz;
        logic [1:0]       src_mode;
    } t_req;

    typedef struct packed {
        logic [3:0] flash_wait_states;
        logic [2:0] apb2_div_code;
        logic [2:0] apb1_div_code;
        logic [2:0] pll_r;
        logic [3:0] pll_q;
        logic [3:0] pll_p;
        logic [8:0] pll_n;
        logic [5:0] pll_m;
        logic       pll_found;
        logic       pll_enable;
        logic       src_error;
        logic       use_external;
    } t_plan;

    // flash wait-state step by supply band
    function automatic logic [ACC_W-1:0] flash_step(input logic [1:0] band);
        logic [ACC_W-1:0] s;
        begin
            unique case (band)
                2'd0: s = 29'd30000000;
                2'd1: s = 29'd24000000;
                2'd2: s = 29'd22000000;
                2'd3: s = 29'd20000000;
                default: s = 29'd20000000;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== hdl/pcps_div.sv =====
// restoring divider, one quotient bit per cycle, source frequency over m
module pcps_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcps_pkg::SRC_W-1:0]    i_dividend,
    input  logic [5:0]                    i_divisor,
    output logic                          o_done,
    output logic [pcps_pkg::SRC_W-1:0]    o_quot
);

    logic                              r_busy;
    logic [pcps_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [5:0]                        r_dvs;
    logic [5:0]                        r_rem;
    logic [pcps_pkg::SRC_W-1:0]        r_quo;
    logic [6:0]                        w_trial;
    logic                              w_ge;
    logic [6:0]                        w_diff;

    assign w_trial = {r_rem, r_quo[pcps_pkg::SRC_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign o_done  = r_busy && (r_cnt == pcps_pkg::DIV_CNT_W'(pcps_pkg::DIV_STEPS - 1));
    assign o_quot  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_dvs  <= i_divisor;
            r_rem  <= '0;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[5:0] : w_trial[5:0];
            r_quo <= {r_quo[pcps_pkg::SRC_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/pll_clock_plan_solver_top.sv =====
// pll clock plan solver top level: source choice, pll search, apb and flash settings
//
// One request beat in, one plan beat out. The source choice and the bypass test are
// made in the accept cycle; a bypassed request goes straight to the wait-state and APB
// steps. Otherwise a setup step comes first, then each M from 2 to 63 runs the shared
// bit-serial divider for source/M, the VCO is formed at N=50, then N is stepped (the VCO
// grows by source/M each step and all four P values are checked at each step); an M is
// left as soon as the VCO passes 432 MHz. The serial wait-state and APB steps follow.
// The input is not ready until the plan beat has been taken.
module pll_clock_plan_solver_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [pcps_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // src_mode, ext_freq_hz, hse_ready, target_freq_hz, apb1_manual, apb1_target_hz,
    // apb2_manual, apb2_target_hz, zero pad
    input  logic [pcps_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // use_external, src_error, pll_enable, pll_found, pll_m, pll_n, pll_p, pll_q, pll_r,
    // apb1_div_code, apb2_div_code, flash_wait_states
    output logic [pcps_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_VCO   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_PINIT = 3'd5;
    localparam logic [2:0] S_POST  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]                        r_state;
    logic [pcps_pkg::SRC_W-1:0]        r_int_osc;
    logic [1:0]                        r_band;

    logic [pcps_pkg::SRC_W-1:0]        r_src;
    logic [pcps_pkg::HCLK_W-1:0]       r_tgt;
    logic [30:0]                       r_t6;
    logic                              r_bypass;
    logic                              r_a1man;
    logic [31:0]                       r_a1t;
    logic                              r_a2man;
    logic [31:0]                       r_a2t;
    logic [5:0]                        r_m;
    logic [8:0]                        r_n;
    logic [pcps_pkg::VCO_W-1:0]        r_vco;
    logic [3:0]                        r_cnt;
    logic [pcps_pkg::ACC_W-1:0]        r_ws_acc;
    logic                              r_c1_done;
    logic                              r_c2_done;
    pcps_pkg::t_plan                   r_plan;

    pcps_pkg::t_req                    w_req;
    pcps_pkg::t_plan                   w_plan0;
    logic                              w_use_ext;
    logic [pcps_pkg::SRC_W-1:0]        w_src;
    logic                              w_err;
    logic                              w_bypass;
    logic [pcps_pkg::HCLK_W-1:0]       w_tgt_cap;
    logic                              w_accept;
    logic                              w_div_start;
    logic [5:0]                        w_div_m;
    logic                              w_div_done;
    logic [pcps_pkg::SRC_W-1:0]        w_quot;
    logic [pcps_pkg::VCO_W-1:0]        w_q35;
    logic                              w_hit2;
    logic                              w_hit4;
    logic                              w_hit6;
    logic                              w_hit8;
    logic                              w_in_rng;
    logic                              w_next_m;
    logic [pcps_pkg::ACC_W-1:0]        w_step;
    logic [31:0]                       w_hshift;

    function automatic logic vco_hit(
        input logic [pcps_pkg::VCO_W-1:0] vco,
        input logic [pcps_pkg::VCO_W-1:0] tp,
        input logic [3:0]                 p
    );
        logic [pcps_pkg::VCO_W-1:0] d;
        begin
            d = vco - tp;
            return (vco >= tp) && (d < pcps_pkg::VCO_W'(p));
        end
    endfunction

    assign w_req     = pcps_pkg::t_req'(i_s_axis_tdata[pcps_pkg::REQ_W-1:0]);
    assign w_use_ext = ((w_req.src_mode == pcps_pkg::MODE_AUTO) ||
                        (w_req.src_mode == pcps_pkg::MODE_EXT)) &&
                       (w_req.ext_freq_hz != '0) && w_req.hse_ready;
    assign w_src     = w_use_ext ? w_req.ext_freq_hz : r_int_osc;
    assign w_err     = ((w_req.src_mode == pcps_pkg::MODE_EXT) && !w_use_ext) ||
                       (w_req.src_mode == pcps_pkg::MODE_BAD);
    assign w_bypass  = w_req.target_freq_hz == 32'(w_src);
    assign w_tgt_cap = (w_req.target_freq_hz > pcps_pkg::SYS_MAX_HZ) ?
                       pcps_pkg::SYS_MAX_HZ[pcps_pkg::HCLK_W-1:0] :
                       w_req.target_freq_hz[pcps_pkg::HCLK_W-1:0];

    // plan fields known at accept, the rest cleared
    always_comb begin
        w_plan0              = '0;
        w_plan0.use_external = w_use_ext;
        w_plan0.src_error    = w_err;
        w_plan0.pll_enable   = !w_bypass;
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_state == S_OUT;
    assign o_m_axis_tdata  = r_plan;

    // divider start: first m from prep, next m from the scan
    assign w_div_m     = (r_state == S_PREP) ? pcps_pkg::M_FIRST : r_m + 6'd1;
    assign w_div_start = (r_state == S_PREP) || (w_next_m && (r_m != pcps_pkg::M_LAST));

    pcps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_src),
        .i_divisor  (w_div_m),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_q35    = pcps_pkg::VCO_W'(w_quot);
    assign w_hit2   = vco_hit(r_vco, pcps_pkg::VCO_W'({r_tgt, 1'b0}), 4'd2);
    assign w_hit4   = vco_hit(r_vco, pcps_pkg::VCO_W'({r_tgt, 2'b0}), 4'd4);
    assign w_hit6   = vco_hit(r_vco, pcps_pkg::VCO_W'(r_t6), 4'd6);
    assign w_hit8   = vco_hit(r_vco, pcps_pkg::VCO_W'({r_tgt, 3'b0}), 4'd8);
    assign w_in_rng = (r_vco >= pcps_pkg::VCO_MIN_HZ) && (r_vco <= pcps_pkg::VCO_MAX_HZ);
    assign w_next_m = (r_state == S_SCAN) &&
                      ((r_vco > pcps_pkg::VCO_MAX_HZ) ||
                       (!(w_in_rng && (w_hit2 || w_hit4 || w_hit6 || w_hit8)) &&
                        (r_n == pcps_pkg::N_LAST)));

    assign w_step   = pcps_pkg::flash_step(r_band);
    assign w_hshift = 32'(r_tgt >> r_cnt[2:0]);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_osc <= pcps_pkg::INT_OSC_RST;
            r_band    <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pcps_pkg::CFG_INT_OSC: r_int_osc <= i_cfg_wdata;
                pcps_pkg::CFG_SUPPLY:  r_band    <= i_cfg_wdata[1:0];
                default:               r_band    <= r_band;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_src                <= w_src;
                        r_tgt                <= w_tgt_cap;
                        r_bypass             <= w_bypass;
                        r_a1man              <= w_req.apb1_manual;
                        r_a1t                <= w_req.apb1_target_hz;
                        r_a2man              <= w_req.apb2_manual;
                        r_a2t                <= w_req.apb2_target_hz;
                        r_plan               <= w_plan0;
                        r_state              <= w_bypass ? S_PINIT : S_PREP;
                    end
                end
                S_PREP: begin
                    r_t6    <= 31'({r_tgt, 2'b0}) + 31'({r_tgt, 1'b0});
                    r_m     <= pcps_pkg::M_FIRST;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_VCO;
                    end
                end
                S_VCO: begin
                    r_vco   <= (w_q35 << 5) + (w_q35 << 4) + (w_q35 << 1);
                    r_n     <= pcps_pkg::N_FIRST;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    priority if (r_vco > pcps_pkg::VCO_MAX_HZ || w_next_m) begin
                        if (r_m == pcps_pkg::M_LAST) begin
                            r_state <= S_PINIT;
                        end else begin
                            r_m     <= r_m + 6'd1;
                            r_state <= S_DIV;
                        end
                    end else if (w_in_rng && (w_hit2 || w_hit4 || w_hit6 || w_hit8)) begin
                        r_plan.pll_found <= 1'b1;
                        r_plan.pll_m     <= r_m;
                        r_plan.pll_n     <= r_n;
                        priority if (w_hit2) begin
                            r_plan.pll_p <= 4'd2;
                            r_plan.pll_q <= 4'd2;
                            r_plan.pll_r <= 3'd2;
                        end else if (w_hit4) begin
                            r_plan.pll_p <= 4'd4;
                            r_plan.pll_q <= 4'd4;
                            r_plan.pll_r <= 3'd4;
                        end else if (w_hit6) begin
                            r_plan.pll_p <= 4'd6;
                            r_plan.pll_q <= 4'd6;
                            r_plan.pll_r <= 3'd6;
                        end else begin
                            // vco/7 is always within the system limit
                            r_plan.pll_p <= 4'd8;
                            r_plan.pll_q <= 4'd8;
                            r_plan.pll_r <= 3'd7;
                        end
                        r_state <= S_PINIT;
                    end else begin
                        r_n   <= r_n + 9'd1;
                        r_vco <= r_vco + w_q35;
                    end
                end
                S_PINIT: begin
                    r_cnt                    <= '0;
                    r_ws_acc                 <= w_step;
                    r_plan.flash_wait_states <= '0;
                    if (r_bypass) begin
                        r_plan.apb1_div_code <= '0;
                        r_c1_done            <= 1'b1;
                        r_plan.apb2_div_code <= '0;
                        r_c2_done            <= 1'b1;
                    end else begin
                        r_c1_done <= !r_a1man;
                        r_c2_done <= !r_a2man;
                        if (r_a1man) begin
                            r_plan.apb1_div_code <= pcps_pkg::APB_CODE_MAX;
                        end else if (r_tgt <= pcps_pkg::APB1_STEP0_HZ) begin
                            r_plan.apb1_div_code <= 3'd0;
                        end else if (r_tgt <= pcps_pkg::APB_STEP1_HZ) begin
                            r_plan.apb1_div_code <= 3'd1;
                        end else begin
                            r_plan.apb1_div_code <= 3'd2;
                        end
                        if (r_a2man) begin
                            r_plan.apb2_div_code <= pcps_pkg::APB_CODE_MAX;
                        end else begin
                            r_plan.apb2_div_code <= (r_tgt <= pcps_pkg::APB_STEP1_HZ) ?
                                                    3'd0 : 3'd1;
                        end
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    // wait states: smallest w with f <= step*(w+1)
                    if (({1'b0, r_tgt} > r_ws_acc) &&
                        (r_plan.flash_wait_states != pcps_pkg::WS_MAX)) begin
                        r_plan.flash_wait_states <= r_plan.flash_wait_states + 4'd1;
                        r_ws_acc                 <= r_ws_acc + w_step;
                    end
                    // manual apb: walk the divider ladder from /1
                    if (r_cnt <= 4'(pcps_pkg::APB_CODE_MAX)) begin
                        if (!r_c1_done) begin
                            if (w_hshift == r_a1t) begin
                                r_plan.apb1_div_code <= r_cnt[2:0];
                                r_c1_done            <= 1'b1;
                            end else if (w_hshift < r_a1t) begin
                                r_plan.apb1_div_code <= (r_cnt == '0) ? 3'd0 :
                                                        r_cnt[2:0] - 3'd1;
                                r_c1_done            <= 1'b1;
                            end
                        end
                        if (!r_c2_done) begin
                            if (w_hshift == r_a2t) begin
                                r_plan.apb2_div_code <= r_cnt[2:0];
                                r_c2_done            <= 1'b1;
                            end else if (w_hshift < r_a2t) begin
                                r_plan.apb2_div_code <= (r_cnt == '0) ? 3'd0 :
                                                        r_cnt[2:0] - 3'd1;
                                r_c2_done            <= 1'b1;
                            end
                        end
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == pcps_pkg::POST_LAST) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tb_pll_clock_plan_solver_top.sv =====
// self-checking testbench for the pll clock plan solver: directed and random requests
module tb_pll_clock_plan_solver_top;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam longint unsigned HCLK_MAX = 64'd216000000;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic                             cfg_addr = pcps_pkg::CFG_INT_OSC;
    logic [pcps_pkg::CFG_W-1:0]       cfg_wdata = '0;
    logic                             req_valid = 1'b0;
    logic                             req_ready;
    logic [pcps_pkg::IN_TDATA_W-1:0]  req_data = '0;
    logic                             plan_valid;
    logic                             plan_ready = 1'b0;
    logic [pcps_pkg::OUT_TDATA_W-1:0] plan_data;

    // predictor copy of the configuration
    logic [pcps_pkg::SRC_W-1:0] osc_hz = pcps_pkg::INT_OSC_RST;
    logic [1:0]                 band = 2'd0;

    pcps_pkg::t_req  reqs_pending[$];
    pcps_pkg::t_plan plans_due[$];
    int unsigned reqs_offered = 0;
    int unsigned reqs_taken = 0;
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          quiet = 1'b0;

    pll_clock_plan_solver_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (plan_valid),
        .i_m_axis_tready (plan_ready),
        .o_m_axis_tdata  (plan_data)
    );

    always #5 clk = ~clk;

    function automatic logic [3:0] flash_waits(input longint unsigned f);
        longint unsigned step;
        longint unsigned w;
        case (band)
            2'd0: step = 64'd30000000;
            2'd1: step = 64'd24000000;
            2'd2: step = 64'd22000000;
            default: step = 64'd20000000;
        endcase
        if (f == 0) return 4'd0;
        w = (f - 1) / step;
        return (w > 9) ? pcps_pkg::WS_MAX : w[3:0];
    endfunction

    function automatic logic [2:0] apb_code(input longint unsigned hclk,
                                            input longint unsigned want);
        longint unsigned f;
        for (int i = 0; i < 5; i++) begin
            f = hclk >> i;
            if (f == want) return i[2:0];
            if (f < want) return (i == 0) ? 3'd0 : 3'(i - 1);
        end
        return pcps_pkg::APB_CODE_MAX;
    endfunction

    function automatic pcps_pkg::t_plan solve_plan(input pcps_pkg::t_req rq);
        pcps_pkg::t_plan pl;
        longint unsigned src, tgt, per_m, vco, pc;
        bit              use_ext, hit, stop;
        pl = '0;
        use_ext = (rq.src_mode <= pcps_pkg::MODE_EXT) && (rq.ext_freq_hz != 0) &&
                  rq.hse_ready;
        src = use_ext ? longint'(rq.ext_freq_hz) : longint'(osc_hz);
        pl.use_external = use_ext;
        pl.src_error = (rq.src_mode == pcps_pkg::MODE_EXT && !use_ext) ||
                       (rq.src_mode == pcps_pkg::MODE_BAD);
        tgt = rq.target_freq_hz;
        if (tgt == src) begin
            pl.flash_wait_states = flash_waits(tgt);
        end else begin
            pl.pll_enable = 1'b1;
            if (tgt > HCLK_MAX) tgt = HCLK_MAX;
            hit = 1'b0;
            for (int m = 2; m <= 63 && !hit; m++) begin
                per_m = src / m;
                for (int n = 50; n <= 432 && !hit; n++) begin
                    vco = per_m * n;
                    if (vco >= 64'd100000000 && vco <= 64'd432000000) begin
                        stop = 1'b0;
                        for (int p = 2; p <= 8 && !hit && !stop; p += 2) begin
                            pc = vco / p;
                            if (pc < tgt) begin
                                stop = 1'b1;
                            end else if (pc == tgt) begin
                                hit = 1'b1;
                                pl.pll_found = 1'b1;
                                pl.pll_m = m[5:0];
                                pl.pll_n = n[8:0];
                                pl.pll_p = p[3:0];
                                pl.pll_q = p[3:0];
                                // vco/7 never exceeds the system limit
                                pl.pll_r = (p <= 7) ? p[2:0] : 3'd7;
                            end
                        end
                    end
                end
            end
            if (rq.apb1_manual)
                pl.apb1_div_code = apb_code(tgt, rq.apb1_target_hz);
            else
                pl.apb1_div_code = (tgt <= 64'd54000000) ? 3'd0 :
                                   (tgt <= 64'd108000000) ? 3'd1 : 3'd2;
            if (rq.apb2_manual)
                pl.apb2_div_code = apb_code(tgt, rq.apb2_target_hz);
            else
                pl.apb2_div_code = (tgt <= 64'd108000000) ? 3'd0 : 3'd1;
            pl.flash_wait_states = flash_waits(tgt);
        end
        return pl;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic add_req(input logic [1:0] mode, input logic [pcps_pkg::SRC_W-1:0] ext,
                           input logic ready, input logic [31:0] target,
                           input logic a1m, input logic [31:0] a1t,
                           input logic a2m, input logic [31:0] a2t);
        pcps_pkg::t_req rq;
        rq.src_mode = mode;
        rq.ext_freq_hz = ext;
        rq.hse_ready = ready;
        rq.target_freq_hz = target;
        rq.apb1_manual = a1m;
        rq.apb1_target_hz = a1t;
        rq.apb2_manual = a2m;
        rq.apb2_target_hz = a2t;
        reqs_pending.push_back(rq);
    endtask

    function automatic logic [31:0] bus_want(input longint unsigned hclk);
        longint unsigned f;
        f = hclk >> $urandom_range(0, 4);
        case ($urandom_range(0, 5))
            0: return f[31:0];
            1: return 32'(f + 1);
            2: return 32'(f - 1);
            3: return 32'd0;
            4: return $urandom_range(0, 32'(hclk));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random(input int count);
        pcps_pkg::t_req  rq;
        longint unsigned src, vco, hclk;
        int              kind, m, n;
        bit              ok;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: rq.src_mode = pcps_pkg::MODE_AUTO;
                4, 5, 6:    rq.src_mode = pcps_pkg::MODE_EXT;
                7, 8:       rq.src_mode = pcps_pkg::MODE_INT;
                default:    rq.src_mode = pcps_pkg::MODE_BAD;
            endcase
            case ($urandom_range(0, 9))
                0:       rq.ext_freq_hz = '0;
                1, 2:    rq.ext_freq_hz = 26'($urandom_range(1, 50000000));
                default: rq.ext_freq_hz = 26'($urandom_range(4000000, 26000000));
            endcase
            rq.hse_ready = ($urandom_range(0, 6) != 0);
            src = (rq.src_mode <= pcps_pkg::MODE_EXT && rq.ext_freq_hz != 0 &&
                   rq.hse_ready) ? longint'(rq.ext_freq_hz) : longint'(osc_hz);
            if (kind < 12) begin
                rq.target_freq_hz = src[31:0];
            end else if (kind < 27) begin
                rq.target_freq_hz = $urandom;
            end else begin
                ok = 1'b0;
                for (int t = 0; t < 20 && !ok; t++) begin
                    m = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 63) :
                        $urandom_range(2, 8);
                    n = $urandom_range(50, 432);
                    vco = (src / m) * n;
                    if (vco >= 64'd100000000 && vco <= 64'd432000000) begin
                        ok = 1'b1;
                        rq.target_freq_hz = 32'(vco / (2 * $urandom_range(1, 4)));
                    end
                end
                if (!ok) rq.target_freq_hz = $urandom_range(1, 216000000);
            end
            hclk = (rq.target_freq_hz > HCLK_MAX) ? HCLK_MAX : rq.target_freq_hz;
            rq.apb1_manual = 1'($urandom_range(0, 1));
            rq.apb1_target_hz = bus_want(hclk);
            rq.apb2_manual = 1'($urandom_range(0, 1));
            rq.apb2_target_hz = bus_want(hclk);
            reqs_pending.push_back(rq);
        end
    endtask

    task automatic drain();
        while (!(reqs_pending.size() == 0 && reqs_offered == reqs_taken &&
                 plans_due.size() == 0))
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [pcps_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        if (idx == pcps_pkg::CFG_INT_OSC)
            osc_hz = val;
        else
            band = val[1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // request driver
    always @(negedge clk) begin
        pcps_pkg::t_req nxt;
        if (rst_n && !(req_valid && reqs_offered != reqs_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                req_valid <= 1'b0;
            end else if (reqs_pending.size() > 0) begin
                nxt = reqs_pending.pop_front();
                req_data <= {{(pcps_pkg::IN_TDATA_W-pcps_pkg::REQ_W){1'b0}}, nxt};
                req_valid <= 1'b1;
                reqs_offered++;
                if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 10);
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // plan sink stalls
    always @(negedge clk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            plan_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 10) - 1;
            plan_ready <= 1'b0;
        end else begin
            plan_ready <= 1'b1;
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk) begin
        pcps_pkg::t_plan got, want;
        if (rst_n) begin
            if (plan_valid && plan_ready) begin
                got = plan_data;
                if (plans_due.size() == 0) begin
                    $error("plan beat with no request outstanding");
                    errors++;
                end else begin
                    want = plans_due.pop_front();
                    check_field("use_external", want.use_external, got.use_external);
                    check_field("src_error", want.src_error, got.src_error);
                    check_field("pll_enable", want.pll_enable, got.pll_enable);
                    check_field("pll_found", want.pll_found, got.pll_found);
                    check_field("pll_m", want.pll_m, got.pll_m);
                    check_field("pll_n", want.pll_n, got.pll_n);
                    check_field("pll_p", want.pll_p, got.pll_p);
                    check_field("pll_q", want.pll_q, got.pll_q);
                    check_field("pll_r", want.pll_r, got.pll_r);
                    check_field("apb1_div_code", want.apb1_div_code, got.apb1_div_code);
                    check_field("apb2_div_code", want.apb2_div_code, got.apb2_div_code);
                    check_field("flash_wait_states", want.flash_wait_states,
                                got.flash_wait_states);
                end
            end
            if (req_valid && req_ready) begin
                plans_due.push_back(solve_plan(req_data[pcps_pkg::REQ_W-1:0]));
                reqs_taken++;
            end
            if ((plan_valid && plan_ready) || (req_valid && req_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed requests under the reset configuration
        add_req(pcps_pkg::MODE_AUTO, 26'd8000000, 1'b1, 32'd8000000, 1'b0, 32'd0, 1'b0,
                32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b1, 32'd16000000, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_EXT, 26'd25000000, 1'b0, 32'd100000000, 1'b0, 32'd0, 1'b0,
                32'd0);
        add_req(pcps_pkg::MODE_EXT, 26'd0, 1'b1, 32'd96000000, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_EXT, 26'd25000000, 1'b1, 32'd180000000, 1'b1, 32'd0, 1'b1,
                32'h80000000);
        add_req(pcps_pkg::MODE_INT, 26'd25000000, 1'b1, 32'd216000000, 1'b0, 32'd0, 1'b0,
                32'd0);
        add_req(pcps_pkg::MODE_BAD, 26'd12000000, 1'b1, 32'd48000000, 1'b0, 32'd0, 1'b0,
                32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd25000000, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd50000000, 1'b1, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF,
                1'b1, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd1, 1'b1, 32'd1, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd1, 1'b1, 32'd100000000, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd13500000, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd100000000, 1'b1, 32'd12500000, 1'b1,
                32'd100000000);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd200000000, 1'b1, 32'd50000001, 1'b1,
                32'd49999999);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd54000000, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd54000001, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd108000000, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd108000001, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd30000000, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd30000001, 1'b0, 32'd0, 1'b0, 32'd0);
        add_req(pcps_pkg::MODE_AUTO, 26'd0, 1'b0, 32'd216000000, 1'b0, 32'd0, 1'b0, 32'd0);
        drain();

        write_cfg(pcps_pkg::CFG_INT_OSC, 26'd1);
        write_cfg(pcps_pkg::CFG_SUPPLY, 26'd3);
        add_random(16);
        drain();

        write_cfg(pcps_pkg::CFG_INT_OSC, 26'd50000000);
        write_cfg(pcps_pkg::CFG_SUPPLY, 26'd1);
        add_random(16);
        drain();

        write_cfg(pcps_pkg::CFG_INT_OSC, 26'd16000000);
        write_cfg(pcps_pkg::CFG_SUPPLY, 26'd2);
        add_random(16);
        drain();

        write_cfg(pcps_pkg::CFG_INT_OSC, 26'($urandom_range(1, 50000000)));
        write_cfg(pcps_pkg::CFG_SUPPLY, 26'($urandom_range(0, 3)));
        add_random(16);
        drain();

        // no idling on either side from here on
        quiet = 1'b1;
        add_random(16);
        drain();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== pll_clock_plan_solver_top.f =====
hdl/pcps_pkg.sv
hdl/pcps_div.sv
hdl/pll_clock_plan_solver_top.sv
sim/tb_pll_clock_plan_solver_top.sv
